// File: hdl/r250_pkg.sv
// ----------------------------------------------------------------------------
// r250_pkg
// Shared types and constants of the R250 lagged XOR generator: the lags, the
// default seed table, the controller states and the command/status words.
// ----------------------------------------------------------------------------
`default_nettype none

package r250_pkg;

	// Lags of the recurrence word[j] = word[j-147] ^ word[j-250].
	localparam int unsigned LAG_SHORT   = 147;
	localparam int unsigned LAG_LONG    = 250;
	localparam int unsigned TABLE_WORDS = 256;

	// Function codes of an input word.
	localparam logic FUNC_DRAW = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// Built-in default seed table, loaded into the ring after reset.
	localparam logic [31:0] DEFAULT_SEED [TABLE_WORDS] = '{
		32'd2183635719, 32'd2190244759, 32'd1838922374, 32'd2492928253,
		32'd1691620525, 32'd4174268300, 32'd2925036378, 32'd1686150634,
		32'd4143523061, 32'd92006323, 32'd4177728194, 32'd1411981943,
		32'd1245853850, 32'd1521440829, 32'd2963330919, 32'd856290965,
		32'd2647997580, 32'd2981053599, 32'd1099760386, 32'd3284599097,
		32'd1153699365, 32'd604329032, 32'd2976899913, 32'd3519137272,
		32'd4184227608, 32'd2072347806, 32'd731765320, 32'd3731617640,
		32'd2011825539, 32'd3519091383, 32'd777911520, 32'd3593825682,
		32'd2213846057, 32'd2818450139, 32'd1518574725, 32'd3087387789,
		32'd2839883236, 32'd2917794674, 32'd911197067, 32'd211765470,
		32'd428397452, 32'd2446693707, 32'd921325450, 32'd135181643,
		32'd2748792785, 32'd1430813481, 32'd2819005913, 32'd1794303866,
		32'd1684166381, 32'd2236579585, 32'd183216389, 32'd22600318,
		32'd424653856, 32'd3742353884, 32'd3645276761, 32'd2061915755,
		32'd3915077421, 32'd600520186, 32'd556839987, 32'd734918579,
		32'd2120203728, 32'd2899243738, 32'd1481433027, 32'd2344617992,
		32'd1599513085, 32'd1398259692, 32'd1670606037, 32'd648503549,
		32'd1539868690, 32'd128537250, 32'd3997202055, 32'd2749540959,
		32'd327991835, 32'd2963440711, 32'd3023804961, 32'd4077646674,
		32'd1658275422, 32'd2090997227, 32'd3780061296, 32'd2729972273,
		32'd1926252795, 32'd3202049657, 32'd3879207852, 32'd1900755841,
		32'd2480152485, 32'd561994355, 32'd1380333390, 32'd2134798066,
		32'd2128088413, 32'd14348827, 32'd1584549315, 32'd2472893490,
		32'd2427233072, 32'd3471354632, 32'd3092802058, 32'd3537096898,
		32'd3131526979, 32'd600558991, 32'd729675831, 32'd712609463,
		32'd2977016554, 32'd3732375413, 32'd2921287250, 32'd2698425775,
		32'd57604637, 32'd2706609512, 32'd632385541, 32'd2012671337,
		32'd2010953452, 32'd824814095, 32'd1619673816, 32'd767630393,
		32'd195784944, 32'd662004853, 32'd3374593664, 32'd1653069366,
		32'd1323411388, 32'd2229537257, 32'd2587783893, 32'd447703779,
		32'd1687964944, 32'd3616195188, 32'd4227645990, 32'd3873208902,
		32'd2630042627, 32'd718425856, 32'd706712992, 32'd2272163330,
		32'd2123548242, 32'd3052380041, 32'd1286900347, 32'd3030225619,
		32'd3990904814, 32'd460716308, 32'd685339369, 32'd834928970,
		32'd2129756172, 32'd495105944, 32'd4161716583, 32'd4257896697,
		32'd1728169764, 32'd777344186, 32'd3790271563, 32'd569734115,
		32'd4136669083, 32'd3156717764, 32'd1113962257, 32'd1250225371,
		32'd666738466, 32'd3660168312, 32'd2582701982, 32'd2927556822,
		32'd2309677514, 32'd4228759946, 32'd4275226748, 32'd1917759123,
		32'd2301422716, 32'd3325595869, 32'd3600918959, 32'd1507742373,
		32'd2189228943, 32'd1354410878, 32'd1893866291, 32'd3405482202,
		32'd258140360, 32'd3412838799, 32'd789120517, 32'd1774390742,
		32'd1276112849, 32'd2971021240, 32'd661478379, 32'd2366454877,
		32'd1350258451, 32'd3269346974, 32'd1568983620, 32'd366528176,
		32'd1512560683, 32'd428458871, 32'd2837985004, 32'd1145283036,
		32'd3488172914, 32'd2830841878, 32'd578995039, 32'd1783082104,
		32'd763626672, 32'd3609683706, 32'd997748244, 32'd291508732,
		32'd1082754828, 32'd1793724907, 32'd445425176, 32'd306544940,
		32'd1141049923, 32'd2340771713, 32'd2695001510, 32'd1039741825,
		32'd25338870, 32'd1961306592, 32'd1970584190, 32'd1932328866,
		32'd70484709, 32'd2794213096, 32'd1947251298, 32'd2384361454,
		32'd1532598777, 32'd1413594045, 32'd3741770196, 32'd3341090742,
		32'd3425538499, 32'd1077106632, 32'd679120682, 32'd548535452,
		32'd1785460316, 32'd2833553614, 32'd2641172924, 32'd3482103930,
		32'd2922868348, 32'd3452689737, 32'd778677809, 32'd1852367327,
		32'd3185222054, 32'd2475234521, 32'd1105940197, 32'd188880018,
		32'd3701380499, 32'd4075520071, 32'd3197904393, 32'd3346375591,
		32'd2092415115, 32'd3541136001, 32'd1609674945, 32'd2334264928,
		32'd442922817, 32'd3551460990, 32'd96703578, 32'd355623315,
		32'd1838176107, 32'd2630741652, 32'd2614239307, 32'd947656070,
		32'd1720998510, 32'd1260963745, 32'd412104712, 32'd2897568188,
		32'd504494002, 32'd409223266, 32'd13584767, 32'd4006567101,
		32'd1443312917, 32'd1985791450, 32'd1428736195, 32'd3128819800,
		32'd4106263747, 32'd2661162000, 32'd2440997736, 32'd3111816589
	};

	// Controller states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_REFRESH,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_wr;    // write one default table word during the initial fill
		logic seed_wr;    // write a seed word and mark a refresh as pending
		logic draw_rd;    // read the word at the read position and advance it
		logic ref_start;  // set up the refresh pointers and clear the read position
		logic ref_issue;  // issue the reads of one refresh step
		logic out_valid;  // present the drawn word
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;     // last word of the initial fill
		logic need_refresh;  // refresh pending or ring used up
		logic step_last;     // last refresh step being issued
	} dp_status_t;

endpackage

`default_nettype wire

// File: hdl/r250_xor_lag_random_generator.sv
// ----------------------------------------------------------------------------
// r250_xor_lag_random_generator
// Draw: random_word with valid comes in the cycle after start is taken, and busy
// is high while it is presented. A draw that refreshes the ring first steps
// through REFRESH, then DRAIN, then presents the word; a load is written while
// the block stays idle. A new input word is not taken until the drawn word has
// been presented; the receiver cannot stall the block. After reset the ring
// is filled from the default table while busy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module r250_xor_lag_random_generator #(
	parameter int unsigned RING_WORDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [7:0]  seed_index,
	input  wire logic [31:0] seed_word,
	output logic [31:0]      random_word,
	output logic             valid
);
	import r250_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencing of fill, loads, refreshes and draws.
	r250_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Ring memory and pointers.
	r250_dp #(
		.RING_WORDS (RING_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_index  (seed_index),
		.seed_word   (seed_word),
		.status      (status),
		.random_word (random_word),
		.valid       (valid)
	);

`ifndef SYNTHESIS
	// A draw gives exactly one word.
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("valid held for more than one cycle");

	// A load gives no word.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_LOAD) |=> !valid)
		else $error("word presented after a seed load");

	// A word only comes while the block is busy with its draw.
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("word presented while idle");
`endif

endmodule

`default_nettype wire

// File: hdl/r250_ctrl.sv
// ----------------------------------------------------------------------------
// r250_ctrl
// Controller of the R250 generator: sequences the initial fill, seed loads,
// ring refreshes and draws, and drives the handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module r250_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 func,
	input  wire r250_pkg::dp_status_t status,
	output r250_pkg::ctrl_cmd_t       cmd,
	output logic                      busy
);
	import r250_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   take_draw;
	logic   take_load;

	// Accepted input words, split by function.
	assign take_draw = (state_q == ST_IDLE) && start && (func == FUNC_DRAW);
	assign take_load = (state_q == ST_IDLE) && start && (func == FUNC_LOAD);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (status.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take_draw) begin
					state_d = status.need_refresh ? ST_REFRESH : ST_OUT;
				end
			end
			ST_REFRESH: begin
				if (status.step_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
				cmd.seed_wr = take_load;
				cmd.draw_rd = take_draw && !status.need_refresh;
				cmd.ref_start = take_draw && status.need_refresh;
			end
			ST_REFRESH: begin
				cmd.ref_issue = 1'b1;
			end
			ST_DRAIN: begin
				// The last refresh write lands while slot 0 is read.
				cmd.draw_rd = 1'b1;
			end
			ST_OUT: begin
				cmd.out_valid = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/r250_dp.sv
// ----------------------------------------------------------------------------
// r250_dp
// Datapath of the R250 generator: the ring memory with one write port and
// two registered read ports, the refresh pointers and the read position.
// ----------------------------------------------------------------------------
`default_nettype none

module r250_dp #(
	parameter int unsigned RING_WORDS = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire r250_pkg::ctrl_cmd_t cmd,
	input  wire logic [7:0]          seed_index,
	input  wire logic [31:0]         seed_word,
	output r250_pkg::dp_status_t     status,
	output logic [31:0]              random_word,
	output logic                     valid
);
	import r250_pkg::*;

	localparam int unsigned AW = $clog2(RING_WORDS);
	localparam int unsigned PW = $clog2(RING_WORDS + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_WORDS - 1);

	logic [31:0]   ring_mem [RING_WORDS];
	logic [AW-1:0] init_cnt_q;
	logic [PW-1:0] pos_q;
	logic          pending_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] a_q;
	logic [AW-1:0] b_q;
	logic          wr_s1;
	logic [AW-1:0] j_s1;
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;
	logic [AW-1:0] ra_a;
	logic [31:0]   init_word;
	logic          seed_in_ring;

	// Default word for the slot being filled; slots past the table are zero.
	assign init_word = ({{(32 - AW){1'b0}}, init_cnt_q} < 32'(TABLE_WORDS))
		? DEFAULT_SEED[init_cnt_q[7:0]] : 32'd0;

	assign seed_in_ring = 32'(seed_index) < 32'(RING_WORDS);

	// Write port select: the controller never asks for two writes at once.
	always_comb begin
		we = 1'b0;
		wa = j_s1;
		wd = rd_a_q ^ rd_b_q;
		if (cmd.init_wr) begin
			we = 1'b1;
			wa = init_cnt_q;
			wd = init_word;
		end else if (cmd.seed_wr) begin
			we = seed_in_ring;
			wa = AW'(seed_index);
			wd = seed_word;
		end else if (wr_s1) begin
			we = 1'b1;
		end
	end

	// Port A reads the draw slot or the short-lag operand.
	assign ra_a = cmd.draw_rd ? pos_q[AW-1:0] : a_q;

	// Ring memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[wa] <= wd;
		end
		rd_a_q <= ring_mem[ra_a];
		rd_b_q <= ring_mem[b_q];
	end

	// Initial fill counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (cmd.init_wr && init_cnt_q != LAST_SLOT) begin
			init_cnt_q <= init_cnt_q + 1'b1;
		end
	end

	// Read position and pending refresh flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pending_q <= 1'b1;
		end else begin
			if (cmd.ref_start) begin
				pos_q <= '0;
				pending_q <= 1'b0;
			end else if (cmd.draw_rd) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.seed_wr) begin
				pending_q <= 1'b1;
			end
		end
	end

	// Refresh pointers: destination and both lag operands advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			a_q <= '0;
			b_q <= '0;
		end else if (cmd.ref_start) begin
			j_q <= AW'(LAG_LONG);
			a_q <= AW'(LAG_LONG - LAG_SHORT);
			b_q <= '0;
		end else if (cmd.ref_issue) begin
			j_q <= (j_q == LAST_SLOT) ? '0 : j_q + 1'b1;
			a_q <= (a_q == LAST_SLOT) ? '0 : a_q + 1'b1;
			b_q <= (b_q == LAST_SLOT) ? '0 : b_q + 1'b1;
		end
	end

	// Write stage of the refresh: the XOR is written in the cycle after the reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.ref_issue;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
	end

	// Status back to the controller.
	assign status.init_last = cmd.init_wr && (init_cnt_q == LAST_SLOT);
	assign status.need_refresh = pending_q || (pos_q == PW'(RING_WORDS));
	assign status.step_last = cmd.ref_issue && (b_q == LAST_SLOT);

	// Drawn word.
	assign random_word = rd_a_q;
	assign valid = cmd.out_valid;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the R250 lagged XOR generator. A short table of
// draw and seed-load words comes first, then long runs of random draws mixed
// with bursts of seed loads. Drawn words are checked against a typed row's
// word or a predictor with its own ring copy, read position and refresh flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import r250_pkg::*;

	localparam int unsigned RING           = 256;
	localparam int          ITEM_COUNT     = 650;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          REPORT_LIMIT   = 10;

	// One row of the directed table; typed rows carry a hand-computed word.
	typedef struct {
		logic        code;
		logic [7:0]  slot;
		logic [31:0] value;
		bit          typed;
		logic [31:0] typed_word;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [7:0]  seed_index;
	logic [31:0] seed_word;
	logic [31:0] random_word;
	logic        valid;

	// Side channel to the monitor: a hand-computed word for the current row.
	bit          row_typed;
	logic [31:0] row_typed_word;

	// Predictor state: ring copy, read position and refresh flag.
	logic [31:0] ring_copy [RING];
	int unsigned ring_pos;
	bit          ring_refresh_due;

	// Drawn words that are still to come out of the block.
	logic [31:0] words_due [$];

	int  items_sent;
	int  draws_taken;
	int  loads_taken;
	int  refresh_count;
	int  wrap_count;
	int  words_checked;
	int  mismatch_count;
	int  idle_cycles;
	bit  gaps_off;

	stim_row_t directed [DIRECTED_ROWS];

	r250_xor_lag_random_generator #(
		.RING_WORDS(RING)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.seed_index(seed_index),
		.seed_word(seed_word),
		.random_word(random_word),
		.valid(valid)
	);

	// Clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predict one draw: refresh the ring in place first when a refresh is
	// pending or every word has been handed out, then read and advance.
	function automatic logic [31:0] draw_from_ring();
		int unsigned j;
		int unsigned a;
		int unsigned b;
		logic [31:0] word;
		if (ring_refresh_due || ring_pos >= RING) begin
			if (!ring_refresh_due)
				wrap_count++;
			refresh_count++;
			for (int unsigned t = 0; t < RING; t++) begin
				j = (LAG_LONG + t) % RING;
				a = (j + RING - LAG_SHORT) % RING;
				b = (j + RING - LAG_LONG) % RING;
				ring_copy[j] = ring_copy[a] ^ ring_copy[b];
			end
			ring_pos = 0;
			ring_refresh_due = 1'b0;
		end
		word = ring_copy[ring_pos];
		ring_pos++;
		return word;
	endfunction

	// Drive one word after a random gap and hold it until the block takes it.
	task automatic send_word(input logic code, input logic [7:0] slot, input logic [31:0] value,
			input bit typed, input logic [31:0] typed_word);
		int r;
		int gap;
		gap = 0;
		if (!gaps_off) begin
			r = $urandom_range(0, 99);
			if (r >= 95)
				gap = $urandom_range(8, 40);
			else if (r >= 70)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		func           <= code;
		seed_index     <= slot;
		seed_word      <= value;
		row_typed      <= typed;
		row_typed_word <= typed_word;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		items_sent++;
	endtask

	// Check drawn words, then update the predictor for the word taken at
	// this edge. Both sides see the values from before the edge.
	always @(posedge clk) begin
		logic [31:0] word;
		if (arst_n) begin
			if (valid === 1'b1) begin
				if (words_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: random_word %h with no draw outstanding",
							$realtime, random_word);
				end else begin
					word = words_due.pop_front();
					words_checked++;
					if (random_word !== word) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: random_word mismatch: expected %h, got %h",
								$realtime, word, random_word);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				if (func == FUNC_LOAD) begin
					loads_taken++;
					if (seed_index < RING)
						ring_copy[seed_index] = seed_word;
					ring_refresh_due = 1'b1;
				end else begin
					draws_taken++;
					word = draw_from_ring();
					words_due.push_back(row_typed ? row_typed_word : word);
				end
			end
			if ((start === 1'b1 && busy === 1'b0) || valid === 1'b1)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: too long without any word moving in either direction.
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [7:0]  slot;
		logic [31:0] value;
		int          r;
		int          len;

		// The first draw after reset is word[109] ^ word[6] of the default
		// table, since the refresh writes slot 0 from those two untouched slots.
		directed = '{
			'{FUNC_DRAW, 8'h00, 32'h0000_0000, 1'b1, 32'h9F71_2955},
			'{FUNC_DRAW, 8'h00, 32'h0000_0000, 1'b0, 32'h0},
			'{FUNC_DRAW, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'h00, 32'h0000_0000, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'h80, 32'h8000_0000, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'h7F, 32'h7FFF_FFFF, 1'b0, 32'h0},
			'{FUNC_DRAW, 8'h55, 32'h5555_5555, 1'b0, 32'h0},
			'{FUNC_DRAW, 8'hAA, 32'hAAAA_AAAA, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'h01, 32'h0000_0001, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'h01, 32'hA5A5_A5A5, 1'b0, 32'h0},
			'{FUNC_DRAW, 8'h00, 32'h0000_0000, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'hFE, 32'h5A5A_5A5A, 1'b0, 32'h0},
			'{FUNC_LOAD, 8'h00, 32'hFFFF_FFFF, 1'b0, 32'h0},
			'{FUNC_DRAW, 8'h00, 32'h0000_0000, 1'b0, 32'h0},
			'{FUNC_DRAW, 8'h00, 32'h0000_0000, 1'b0, 32'h0}
		};

		// Predictor and inputs start from the reset state.
		for (int i = 0; i < RING; i++)
			ring_copy[i] = (i < TABLE_WORDS) ? DEFAULT_SEED[i] : 32'h0;
		ring_pos         = 0;
		ring_refresh_due = 1'b1;
		gaps_off         = 1'b0;
		arst_n         <= 1'b0;
		start          <= 1'b0;
		func           <= FUNC_DRAW;
		seed_index     <= 8'h00;
		seed_word      <= 32'h0;
		row_typed      <= 1'b0;
		row_typed_word <= 32'h0;
		idle_cycles    <= 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_word(directed[i].code, directed[i].slot, directed[i].value,
				directed[i].typed, directed[i].typed_word);

		// One long run of draws so the ring gets used up without a load.
		for (int i = 0; i < 270; i++)
			send_word(FUNC_DRAW, 8'($urandom), $urandom, 1'b0, 32'h0);

		// Mixed bursts: seed loads, short draw runs and the odd long run.
		while (items_sent < ITEM_COUNT) begin
			gaps_off = ($urandom_range(0, 9) < 3);
			r = $urandom_range(0, 99);
			if (r < 25) begin
				len = $urandom_range(1, 8);
				if (len > ITEM_COUNT - items_sent)
					len = ITEM_COUNT - items_sent;
				repeat (len) begin
					r = $urandom_range(0, 9);
					slot = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
					r = $urandom_range(0, 9);
					value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
					send_word(FUNC_LOAD, slot, value, 1'b0, 32'h0);
				end
			end else begin
				len = (r < 30) ? $urandom_range(150, 280) : $urandom_range(1, 20);
				if (len > ITEM_COUNT - items_sent)
					len = ITEM_COUNT - items_sent;
				repeat (len)
					send_word(FUNC_DRAW, 8'($urandom), $urandom, 1'b0, 32'h0);
			end
		end
		start <= 1'b0;

		// Drain the outstanding words, then let the block run on before the summary.
		do
			@(posedge clk);
		while (words_due.size() != 0);
		repeat (8) @(posedge clk);

		$display("Took %0d draws and %0d seed loads, checked %0d words.",
			draws_taken, loads_taken, words_checked);
		$display("Predicted %0d ring refreshes, %0d of them from a used-up ring; %0d mismatches.",
			refresh_count, wrap_count, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
